[hdl/bhtxt_pkg.sv]
// Shared types, register map and constants for the bitmap to half-block text block.
// No dependencies; every other file in hdl/ imports this package.

package bhtxt_pkg;

	// Size defaults for the top level parameters
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Field widths fixed by the interface
	localparam int BYTE_W   = 8;
	localparam int CODE_W   = 8;
	localparam int WIDTH_W  = 9;
	localparam int HEIGHT_W = 11;
	localparam int FBC_W    = 16;

	// One input word carries this many pixels
	localparam int LANES  = 8;
	localparam int LANE_W = 3;

	// APB register port
	localparam int CFG_AW    = 5;
	localparam int CFG_DW    = 32;
	localparam int REG_SEL_W = 3;

	typedef enum logic [REG_SEL_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_CODE_EMPTY   = 3'd2,
		REG_CODE_TOP     = 3'd3,
		REG_CODE_BOTTOM  = 3'd4,
		REG_CODE_BOTH    = 3'd5
	} reg_idx_t;

	// Register reset values
	localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = 9'd8;
	localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 11'd8;
	localparam logic [CODE_W-1:0]   RST_CODE_EMPTY   = 8'd32;
	localparam logic [CODE_W-1:0]   RST_CODE_TOP     = 8'd223;
	localparam logic [CODE_W-1:0]   RST_CODE_BOTTOM  = 8'd220;
	localparam logic [CODE_W-1:0]   RST_CODE_BOTH    = 8'd219;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

	// Output queue between the pixel stage and the master port
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PW    = 2;

	typedef struct packed {
		logic [CODE_W-1:0] code_empty;
		logic [CODE_W-1:0] code_top;
		logic [CODE_W-1:0] code_bottom;
		logic [CODE_W-1:0] code_both;
	} codes_t;

	// One pixel after expansion: what to store and what to emit
	typedef struct packed {
		logic pix;       // pixel value
		logic odd;       // pixel sits in an odd row (read the line buffer)
		logic emit_char; // a character goes out for this pixel
		logic emit_nl;   // a newline follows the character
		logic fdone;     // the newline ends the frame
		logic last;      // the final word goes out for this input word
	} pix_ev_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              fdone;
		logic              last;
	} result_t;

endpackage

[hdl/bhtxt_cfg.sv]
// APB register file plus the geometry values derived from it (last column,
// last row, pixels per frame). Depends on bhtxt_pkg.

module bhtxt_cfg #(
	parameter int MAX_WIDTH  = bhtxt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bhtxt_pkg::MAX_HEIGHT_DEF,
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int PXW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bhtxt_pkg::CFG_AW-1:0]  paddr,
	input  logic [bhtxt_pkg::CFG_DW-1:0]  pwdata,
	output logic [bhtxt_pkg::CFG_DW-1:0]  prdata,
	output logic                          pready,
	output bhtxt_pkg::codes_t             codes,
	output logic [CW-1:0]                 wm1,
	output logic [RW-1:0]                 hm1,
	output logic [PXW-1:0]                pixels
);
	import bhtxt_pkg::*;

	localparam int EWW = $clog2(MAX_WIDTH + 1);
	localparam int EHW = $clog2(MAX_HEIGHT + 1);

	logic [WIDTH_W-1:0]   width_q;
	logic [HEIGHT_W-1:0]  height_q;
	codes_t               codes_q;
	logic [REG_SEL_W-1:0] reg_sel;
	logic                 wr_en;
	logic [EWW-1:0]       eff_w;
	logic [EHW-1:0]       eff_h;
	logic [EWW+EHW-1:0]   area;
	logic [CW-1:0]        wm1_q;
	logic [RW-1:0]        hm1_q;
	logic [PXW-1:0]       pixels_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_AW-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q             <= RST_FRAME_WIDTH;
			height_q            <= RST_FRAME_HEIGHT;
			codes_q.code_empty  <= RST_CODE_EMPTY;
			codes_q.code_top    <= RST_CODE_TOP;
			codes_q.code_bottom <= RST_CODE_BOTTOM;
			codes_q.code_both   <= RST_CODE_BOTH;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:  width_q             <= pwdata[WIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_q            <= pwdata[HEIGHT_W-1:0];
				REG_CODE_EMPTY:   codes_q.code_empty  <= pwdata[CODE_W-1:0];
				REG_CODE_TOP:     codes_q.code_top    <= pwdata[CODE_W-1:0];
				REG_CODE_BOTTOM:  codes_q.code_bottom <= pwdata[CODE_W-1:0];
				REG_CODE_BOTH:    codes_q.code_both   <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			REG_FRAME_WIDTH:  prdata = CFG_DW'(width_q);
			REG_FRAME_HEIGHT: prdata = CFG_DW'(height_q);
			REG_CODE_EMPTY:   prdata = CFG_DW'(codes_q.code_empty);
			REG_CODE_TOP:     prdata = CFG_DW'(codes_q.code_top);
			REG_CODE_BOTTOM:  prdata = CFG_DW'(codes_q.code_bottom);
			REG_CODE_BOTH:    prdata = CFG_DW'(codes_q.code_both);
			default:          prdata = '0;
		endcase
	end

	// Zero reads as one, large values clip to the buffer size
	always_comb begin
		if (width_q == '0)
			eff_w = EWW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			eff_w = EWW'(MAX_WIDTH);
		else
			eff_w = EWW'(width_q);

		if (height_q == '0)
			eff_h = EHW'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT))
			eff_h = EHW'(MAX_HEIGHT);
		else
			eff_h = EHW'(height_q);
	end

	assign area = (EWW+EHW)'(eff_w) * (EWW+EHW)'(eff_h);

	// Derived geometry, refreshed every cycle
	always_ff @(posedge clk) begin
		wm1_q    <= CW'(eff_w - EWW'(1));
		hm1_q    <= RW'(eff_h - EHW'(1));
		pixels_q <= PXW'(area);
	end

	assign codes  = codes_q;
	assign wm1    = wm1_q;
	assign hm1    = hm1_q;
	assign pixels = pixels_q;

endmodule

[hdl/bhtxt_expand.sv]
// Input word register, frame position counters and the pixel bank that
// expands one word into eight pixel entries and hands them out one a cycle while ev_ready is high.
// Depends on bhtxt_pkg.

module bhtxt_expand #(
	parameter int MAX_WIDTH  = bhtxt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bhtxt_pkg::MAX_HEIGHT_DEF,
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int PXW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bhtxt_pkg::BYTE_W-1:0]  s_axis_tdata,
	input  logic [CW-1:0]                 wm1,
	input  logic [RW-1:0]                 hm1,
	input  logic [PXW-1:0]                pixels,
	output logic                          ev_valid,
	input  logic                          ev_ready,
	output bhtxt_pkg::pix_ev_t            ev,
	output logic [CW-1:0]                 ev_col
);
	import bhtxt_pkg::*;

	localparam int POSW = FBC_W + LANE_W;
	localparam int CMPW = (PXW > POSW) ? PXW : POSW;

	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s1;
	logic [LANES-1:0]  mask_s2;
	pix_ev_t           ev_s2  [LANES];
	logic [CW-1:0]     col_s2 [LANES];
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [FBC_W-1:0]  fbc_q;

	logic [LANES-1:0]  issue_oh;
	logic [LANE_W-1:0] issue_idx;
	logic              issue;
	logic [LANES-1:0]  mask_left;
	logic              s1_move;

	logic [LANES-1:0]  mask_d;
	pix_ev_t           ev_d  [LANES];
	logic [CW-1:0]     col_d [LANES];
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	logic              frame_end;

	// Hand out the lowest pending pixel
	assign issue_oh = mask_s2 & (~mask_s2 + LANES'(1));

	always_comb begin
		issue_idx = '0;
		for (int i = 0; i < LANES; i++) begin
			if (issue_oh[i])
				issue_idx = LANE_W'(i);
		end
	end

	assign ev_valid  = |mask_s2;
	assign ev        = ev_s2[issue_idx];
	assign ev_col    = col_s2[issue_idx];
	assign issue     = ev_valid & ev_ready;
	assign mask_left = issue ? (mask_s2 & ~issue_oh) : mask_s2;

	// The bank reloads once its last pixel leaves
	assign s1_move       = valid_s1 & (mask_left == '0);
	assign s_axis_tready = ~valid_s1 | s1_move;

	// Walk the eight pixels of the word through the row/column counters
	always_comb begin
		logic [CW-1:0]   col_v;
		logic [RW-1:0]   row_v;
		logic [POSW-1:0] pos;
		logic            final_row;
		logic            row_end;
		logic            seen;

		col_v = col_q;
		row_v = row_q;
		for (int i = 0; i < LANES; i++) begin
			pos       = {fbc_q, LANE_W'(i)};
			final_row = (row_v >= hm1);
			row_end   = (col_v >= wm1);
			mask_d[i] = (CMPW'(pos) < CMPW'(pixels));
			col_d[i]  = col_v;
			ev_d[i].pix       = byte_s1[LANES-1-i];
			ev_d[i].odd       = row_v[0];
			ev_d[i].emit_char = row_v[0] | final_row;
			ev_d[i].emit_nl   = row_end & (row_v[0] | final_row);
			ev_d[i].fdone     = final_row;
			ev_d[i].last      = 1'b0;
			if (mask_d[i]) begin
				if (row_end) begin
					col_v = '0;
					row_v = final_row ? '0 : RW'(row_v + RW'(1));
				end else begin
					col_v = CW'(col_v + CW'(1));
				end
			end
		end
		col_n = col_v;
		row_n = row_v;

		// Mark the pixel that produces the word's final output
		seen = 1'b0;
		for (int i = LANES - 1; i >= 0; i--) begin
			ev_d[i].last = mask_d[i] & ev_d[i].emit_char & ~seen;
			seen = seen | (mask_d[i] & ev_d[i].emit_char);
		end
	end

	assign frame_end = (CMPW'(fbc_q) >= CMPW'(pixels >> 3));

	// Control: stage valids and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mask_s2  <= '0;
			col_q    <= '0;
			row_q    <= '0;
			fbc_q    <= '0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			mask_s2 <= s1_move ? mask_d : mask_left;
			if (s1_move) begin
				if (frame_end) begin
					col_q <= '0;
					row_q <= '0;
					fbc_q <= '0;
				end else begin
					col_q <= col_n;
					row_q <= row_n;
					fbc_q <= FBC_W'(fbc_q + FBC_W'(1));
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (s_axis_tready & s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
		if (s1_move) begin
			for (int i = 0; i < LANES; i++) begin
				ev_s2[i]  <= ev_d[i];
				col_s2[i] <= col_d[i];
			end
		end
	end

endmodule

[hdl/bhtxt_render.sv]
// Line buffer, pixel stage that picks the character code, and the small
// output queue feeding the master port. Depends on bhtxt_pkg.

module bhtxt_render #(
	parameter int MAX_WIDTH = bhtxt_pkg::MAX_WIDTH_DEF,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ev_valid,
	output logic                          ev_ready,
	input  bhtxt_pkg::pix_ev_t            ev,
	input  logic [CW-1:0]                 ev_col,
	input  bhtxt_pkg::codes_t             codes,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bhtxt_pkg::CODE_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);
	import bhtxt_pkg::*;

	logic        line_mem [0:MAX_WIDTH-1];
	logic        fire;
	logic        valid_s3;
	pix_ev_t     ev_s3;
	logic        upper_s3;

	result_t              outq_q [OUTQ_DEPTH];
	logic [OUTQ_PW-1:0]   wr_ptr_q;
	logic [OUTQ_PW-1:0]   rd_ptr_q;
	logic [OUTQ_PW:0]     count_q;
	logic [OUTQ_PW-1:0]   wr_nxt;
	logic [1:0]           push_n;
	logic                 pop;
	logic [CODE_W-1:0]    char_code;
	result_t              res_a;
	result_t              res_b;
	result_t              head;

	// Take a pixel only if the queue can absorb two more words after this cycle
	assign ev_ready = ((count_q + (OUTQ_PW+1)'(push_n)) <= (OUTQ_PW+1)'(OUTQ_DEPTH - 2));
	assign fire     = ev_valid & ev_ready;

	// Line buffer: even rows write, odd rows read the pixel above
	always_ff @(posedge clk) begin
		if (fire) begin
			if (!ev.odd)
				line_mem[ev_col] <= ev.pix;
			upper_s3 <= line_mem[ev_col];
			ev_s3    <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= fire;
	end

	// Character select
	always_comb begin
		if (ev_s3.odd && upper_s3)
			char_code = ev_s3.pix ? codes.code_both : codes.code_top;
		else if (ev_s3.odd)
			char_code = ev_s3.pix ? codes.code_bottom : codes.code_empty;
		else
			char_code = ev_s3.pix ? codes.code_top : codes.code_empty;
	end

	always_comb begin
		res_a.code  = char_code;
		res_a.fdone = 1'b0;
		res_a.last  = ev_s3.last & ~ev_s3.emit_nl;
		res_b.code  = NEWLINE_CODE;
		res_b.fdone = ev_s3.fdone;
		res_b.last  = ev_s3.last;
	end

	assign push_n = 2'(valid_s3 & ev_s3.emit_char)
	              + 2'(valid_s3 & ev_s3.emit_char & ev_s3.emit_nl);
	assign wr_nxt = OUTQ_PW'(wr_ptr_q + OUTQ_PW'(1));
	assign pop    = m_axis_tvalid & m_axis_tready;

	// Output queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			outq_q[wr_ptr_q] <= res_a;
		if (push_n == 2'd2)
			outq_q[wr_nxt] <= res_b;
	end

	// Output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= OUTQ_PW'(wr_ptr_q + OUTQ_PW'(push_n));
			rd_ptr_q <= OUTQ_PW'(rd_ptr_q + OUTQ_PW'(pop));
			count_q  <= (OUTQ_PW+1)'(count_q + (OUTQ_PW+1)'(push_n) - (OUTQ_PW+1)'(pop));
		end
	end

	assign head          = outq_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = head.code;
	assign m_axis_tuser  = head.fdone;
	assign m_axis_tlast  = head.last;

endmodule

[hdl/bitmap_to_halfblock_text.sv]
// Top level: packed 1-bit bitmap frames in, half-block character codes out.
// Depends on bhtxt_pkg, bhtxt_cfg, bhtxt_expand and bhtxt_render.
//
// Usage
//   Slave stream: one word = eight pixels, MSB first; rows run on across
//   words. A frame is floor(W*H/8)+1 words; bits past W*H are padding.
//   Master stream: one word per character code; newline code after each row
//   pair (and after an unpaired final row), tuser set on the newline that ends
//   the frame, tlast on the last word caused by an input word.
//   APB: registers at byte offsets 0x00 width, 0x04 height, 0x08..0x14 codes
//   for empty, top, bottom and both; write only while the streams are idle.
// Flow
//   An input word passes the input word register, the pixel bank, the pixel
//   stage and the output queue. The pixel stage takes one pixel per cycle while
//   the queue has room; the master port drains one word per cycle while
//   m_axis_tready is high. An input word yields at most 8 pixels and 16 words.
// Reset clears the frame position, the pipeline and the output queue, and
//   loads the register defaults (8x8, codes 32/223/220/219).
// When the receiver stalls, a 4-word output queue fills, then the pixel stage
//   and the input word register hold and s_axis_tready drops.

module bitmap_to_halfblock_text #(
	parameter int MAX_WIDTH  = bhtxt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bhtxt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bhtxt_pkg::CFG_AW-1:0]  paddr,
	input  logic [bhtxt_pkg::CFG_DW-1:0]  pwdata,
	output logic [bhtxt_pkg::CFG_DW-1:0]  prdata,
	output logic                          pready,
	// Pixel words in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bhtxt_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] pixel_byte
	// Characters out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bhtxt_pkg::CODE_W-1:0]  m_axis_tdata,  // [7:0] char_code
	output logic                          m_axis_tuser,  // [0] frame_done
	output logic                          m_axis_tlast
);
	import bhtxt_pkg::*;

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PXW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	codes_t         codes;
	logic [CW-1:0]  wm1;
	logic [RW-1:0]  hm1;
	logic [PXW-1:0] pixels;
	logic           ev_valid;
	logic           ev_ready;
	pix_ev_t        ev;
	logic [CW-1:0]  ev_col;

	bhtxt_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.codes   (codes),
		.wm1     (wm1),
		.hm1     (hm1),
		.pixels  (pixels)
	);

	bhtxt_expand #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_expand (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.wm1           (wm1),
		.hm1           (hm1),
		.pixels        (pixels),
		.ev_valid      (ev_valid),
		.ev_ready      (ev_ready),
		.ev            (ev),
		.ev_col        (ev_col)
	);

	bhtxt_render #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_render (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_valid      (ev_valid),
		.ev_ready      (ev_ready),
		.ev            (ev),
		.ev_col        (ev_col),
		.codes         (codes),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[hdl/bhtxt_port_chk.sv]
// Port-level checks for bitmap_to_halfblock_text, attached by bind.
// Depends on bhtxt_pkg.

module bhtxt_port_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bhtxt_pkg::CODE_W-1:0]  m_axis_tdata,
	input logic                          m_axis_tuser,
	input logic                          m_axis_tlast
);
	import bhtxt_pkg::*;

	// Output queue is empty while in reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output word valid during reset");

	// Pipeline depth: nothing can reach the output in the first cycles after reset
	a_reset_latency: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
		else $error("output word too soon after reset");

	// A stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// Frame end is only flagged on a newline
	a_fdone_newline: assert property (@(posedge clk)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == NEWLINE_CODE)
		else $error("frame end flagged on a non-newline code");

endmodule

bind bitmap_to_halfblock_text bhtxt_port_chk u_port_chk (.*);

[test/bhtxt_sb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the half-block text testbench: predicts the character words
// for each accepted pixel word and checks the words that come out.
// Depends on bhtxt_pkg from hdl/.

package bhtxt_sb_pkg;
	import bhtxt_pkg::*;

	class halfblock_sb;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		codes_t              codes;

		// line buffer and frame position
		bit                  upper_row [MAX_WIDTH_DEF];
		logic [WIDTH_W-1:0]  col_cnt;
		logic [9:0]          row_cnt;
		logic [FBC_W-1:0]    byte_cnt;

		result_t             expected_chars[$];
		int                  errors;

		function new();
			width_reg        = RST_FRAME_WIDTH;
			height_reg       = RST_FRAME_HEIGHT;
			codes.code_empty  = RST_CODE_EMPTY;
			codes.code_top    = RST_CODE_TOP;
			codes.code_bottom = RST_CODE_BOTTOM;
			codes.code_both   = RST_CODE_BOTH;
			foreach (upper_row[i])
				upper_row[i] = 1'b0;
			col_cnt  = '0;
			row_cnt  = '0;
			byte_cnt = '0;
			errors   = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DW-1:0] value);
			case (idx)
				REG_FRAME_WIDTH:  width_reg         = value[WIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_reg        = value[HEIGHT_W-1:0];
				REG_CODE_EMPTY:   codes.code_empty  = value[CODE_W-1:0];
				REG_CODE_TOP:     codes.code_top    = value[CODE_W-1:0];
				REG_CODE_BOTTOM:  codes.code_bottom = value[CODE_W-1:0];
				REG_CODE_BOTH:    codes.code_both   = value[CODE_W-1:0];
				default: ;
			endcase
		endfunction

		// zero counts as one, large values saturate
		function int unsigned eff_width();
			if (width_reg == 0)
				return 1;
			if (width_reg > MAX_WIDTH_DEF)
				return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0)
				return 1;
			if (height_reg > MAX_HEIGHT_DEF)
				return MAX_HEIGHT_DEF;
			return height_reg;
		endfunction

		function int unsigned frame_len();
			return eff_width() * eff_height() / 8 + 1;
		endfunction

		function int unsigned bytes_to_frame_end();
			int unsigned fl;
			fl = frame_len();
			return (byte_cnt < fl) ? fl - byte_cnt : 1;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		// Expand one pixel word into the characters it causes
		function void take_pixel_byte(logic [BYTE_W-1:0] pixel_byte);
			int unsigned w, h, pixels, pos, col;
			logic pix, up;
			bit final_row, row_end, emitted;
			result_t batch[$];
			result_t r;
			w = eff_width();
			h = eff_height();
			pixels = w * h;
			r.fdone = 1'b0;
			r.last  = 1'b0;
			for (int i = 0; i < LANES; i++) begin
				pos       = 8 * int'(byte_cnt) + i;
				pix       = pixel_byte[7 - i];
				col       = col_cnt;
				final_row = (int'(row_cnt) + 1 >= h);
				row_end   = (col + 1 >= w);
				emitted   = 1'b0;
				// padding bits do nothing
				if (pos >= pixels)
					continue;
				if (col >= MAX_WIDTH_DEF)
					col = MAX_WIDTH_DEF - 1;
				if (!row_cnt[0]) begin
					upper_row[col] = pix;
					// unpaired last row goes out on its own
					if (final_row) begin
						r.code  = pix ? codes.code_top : codes.code_empty;
						r.fdone = 1'b0;
						batch.push_back(r);
						emitted = 1'b1;
					end
				end else begin
					up = upper_row[col];
					case ({up, pix})
						2'b11:   r.code = codes.code_both;
						2'b10:   r.code = codes.code_top;
						2'b01:   r.code = codes.code_bottom;
						default: r.code = codes.code_empty;
					endcase
					r.fdone = 1'b0;
					batch.push_back(r);
					emitted = 1'b1;
				end
				if (row_end) begin
					col_cnt = '0;
					if (emitted) begin
						r.code  = NEWLINE_CODE;
						r.fdone = final_row;
						batch.push_back(r);
					end
					if (final_row)
						row_cnt = '0;
					else
						row_cnt = row_cnt + 1'b1;
				end else begin
					col_cnt = col_cnt + 1'b1;
				end
			end

			// last word of the frame clears the position
			if (int'(byte_cnt) + 1 >= frame_len()) begin
				byte_cnt = '0;
				col_cnt  = '0;
				row_cnt  = '0;
			end else begin
				byte_cnt = byte_cnt + 1'b1;
			end

			foreach (batch[k]) begin
				r = batch[k];
				r.last = (k == batch.size() - 1);
				expected_chars.push_back(r);
			end
		endfunction

		function void check_char(logic [CODE_W-1:0] code, logic fdone, logic last);
			result_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected word: char_code %0d frame_done %0b last %0b",
					code, fdone, last);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (code !== want.code) begin
				$error("char_code: expected %0d, got %0d", want.code, code);
				errors++;
			end
			if (fdone !== want.fdone) begin
				$error("frame_done: expected %0b, got %0b", want.fdone, fdone);
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

endpackage

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for bitmap_to_halfblock_text: drives pixel words and APB
// writes, stalls both streams and checks every character word.
// Depends on bhtxt_pkg and bhtxt_sb_pkg.

module tb;
	import bhtxt_pkg::*;
	import bhtxt_sb_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 300;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SPARSE} ready_mode_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata;   // [7:0] pixel_byte
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [CODE_W-1:0] m_axis_tdata;   // [7:0] char_code
	logic              m_axis_tuser;   // [0] frame_done
	logic              m_axis_tlast;

	halfblock_sb sb;
	int          accepted_in;
	int          burst_left;
	int          idle_cycles;

	bitmap_to_halfblock_text DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return NEWLINE_CODE;
			default: return 8'($urandom);
		endcase
	endfunction

	// APB write: setup, access, then idle
	task automatic apb_write(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one pixel word; bursts of random length with random gaps
	task automatic offer(input logic [BYTE_W-1:0] b);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		accepted_in++;
		sb.take_pixel_byte(b);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Sender pause until every expected word is out, plus drain time
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Receiver: stall pattern plus one long hold-off early in the run
	initial begin
		ready_mode_t mode;
		int          hold_left;
		int          span;
		bit          held;
		m_axis_tready <= 1'b0;
		mode      = RDY_ALWAYS;
		hold_left = 0;
		span      = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_char(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			@(negedge clk);
			if (!held && accepted_in >= 8) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				span = $urandom_range(16, 96);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					RDY_ALWAYS: m_axis_tready <= 1'b1;
					RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					RDY_MOSTLY: m_axis_tready <= (span % 4 != 0);
					default:    m_axis_tready <= (span % 5 == 0);
				endcase
			end
		end
	end

	// Watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned w, h;
		int          count;
		int          random_sent;
		sb          = new();
		accepted_in = 0;
		burst_left  = 0;
		random_sent = 0;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Widest row, height zero: fills the whole line buffer, reset codes
		apb_write(REG_FRAME_WIDTH, 32'd511);
		apb_write(REG_FRAME_HEIGHT, 32'd0);
		offer(8'hFF);
		offer(8'h00);
		offer(8'hA5);
		offer(8'h5A);
		offer(8'h80);
		offer(8'h01);
		repeat (27) offer(pick_byte());
		wait_idle();

		// 8x3: all four pairings, unpaired last row, whole padding word
		apb_write(REG_FRAME_WIDTH, 32'd8);
		apb_write(REG_FRAME_HEIGHT, 32'd3);
		apb_write(REG_CODE_EMPTY, 32'h00);
		apb_write(REG_CODE_TOP, 32'hFF);
		apb_write(REG_CODE_BOTTOM, CFG_DW'(NEWLINE_CODE));
		apb_write(REG_CODE_BOTH, 32'h81);
		offer(8'hF0);
		offer(8'hCC);
		offer(8'h3C);
		offer(8'hFF);
		wait_idle();

		// 5x3: padding bit after the frame's last row
		apb_write(REG_FRAME_WIDTH, 32'd5);
		offer(8'hFF);
		offer(8'h55);
		wait_idle();

		// geometry shrunk in the middle of a frame
		apb_write(REG_FRAME_WIDTH, 32'd6);
		apb_write(REG_FRAME_HEIGHT, 32'd4);
		offer(8'hB7);
		wait_idle();
		apb_write(REG_FRAME_WIDTH, 32'd3);
		offer(8'h6C);
		offer(8'h93);
		wait_idle();
		apb_write(REG_FRAME_HEIGHT, 32'd1);
		offer(8'hE1);
		offer(8'h1E);

		// Random phases, mostly whole frames with random pixels
		while (random_sent < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 11))
				0: begin
					w = 256;
					h = $urandom_range(1, 3);
				end
				1: begin
					w = $urandom_range(0, 1);
					h = $urandom_range(0, 1) ? 1024 : 2047;
				end
				2: begin
					w = $urandom_range(257, 511);
					h = $urandom_range(0, 2);
				end
				default: begin
					w = $urandom_range(1, 24);
					h = $urandom_range(1, 9);
				end
			endcase
			apb_write(REG_FRAME_WIDTH, w);
			apb_write(REG_FRAME_HEIGHT, h);
			for (int r = REG_CODE_EMPTY; r <= REG_CODE_BOTH; r++)
				if ($urandom_range(0, 2) == 0)
					apb_write(reg_idx_t'(r), CFG_DW'(pick_code()));
			if ($urandom_range(0, 4) != 0) begin
				count = sb.bytes_to_frame_end();
				if (sb.frame_len() <= 40)
					count += $urandom_range(0, 1) * sb.frame_len();
			end else begin
				count = $urandom_range(1, 12);
			end
			repeat (count) offer(pick_byte());
			random_sent += count;
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/bhtxt_pkg.sv
hdl/bhtxt_cfg.sv
hdl/bhtxt_expand.sv
hdl/bhtxt_render.sv
hdl/bitmap_to_halfblock_text.sv
hdl/bhtxt_port_chk.sv
test/bhtxt_sb_pkg.sv
test/tb.sv
